// ===== src/open_address_hash_table_macros.svh =====
// Assertion shorthands used by the checker of the hash table.
`ifndef OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define OAHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define OAHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/oaht_pkg.sv =====
package oaht_pkg;

    localparam int CAPACITY   = 1024;
    localparam int INIT_SLOTS = 16;
    localparam int SHIFT_STEP = 5;
    localparam int KEY_BITS   = 32;
    localparam int HASH_BITS  = 32;

    localparam int BANK_DEPTH = (CAPACITY > INIT_SLOTS) ? CAPACITY : INIT_SLOTS;
    localparam int IDX_W      = $clog2(BANK_DEPTH);
    localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int NSZ_W      = IDX_W + 2;
    localparam int MIN_W      = IDX_W + 3;
    localparam int CMP_W      = CNT_W + 3;
    localparam int LIM_W      = $clog2(BANK_DEPTH + HASH_BITS + 3);
    localparam int MARK_W     = 2;
    localparam int WORD_W     = MARK_W + HASH_BITS + KEY_BITS;
    localparam int BIG_LIVE   = 1000;

    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 10;
    localparam int TSIZE_W     = 11;
    localparam int USED_W      = 11;
    localparam int IN_TDATA_W  = ((KEY_BITS + HASH_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SLOT_W + TSIZE_W + USED_W + 7) / 8) * 8;

    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } t_mark;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_ADDED     = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FAILED    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_FINAL
    } t_phase;

    typedef enum logic [1:0] {
        RET_ADD_RETRY,
        RET_ADD_DONE,
        RET_REMOVE
    } t_ret;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRB_RD,
        S_PRB_EV,
        S_DISPATCH,
        S_INSERT,
        S_TOMB,
        S_RSZ_CHK,
        S_RSZ_SIZE,
        S_RSZ_CLR,
        S_RSZ_SRC_RD,
        S_RSZ_SRC_EV,
        S_RSZ_WR,
        S_RSZ_DONE,
        S_AFTER_RSZ,
        S_FIN
    } t_state;

endpackage

// ===== src/oaht_ram.sv =====
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/open_address_hash_table.sv =====
// Open-addressing hash table with tombstones and perturbed probing. Requests
// (lookup, add, remove) are taken one at a time; s_axis_tready is high only
// while the table is idle, and a finished result waits in the output register
// while the next request is accepted. All work runs through one table memory
// (one read and one write port) and one probe-step adder under a sequencer.
// A request reads and evaluates one slot per probe step; an add probes up to three
// times. A resize clears every slot of the new table, then reads each slot of the
// old table and probes the new table to move each live entry. After reset the
// table clears its first bank before it accepts a request; configuration writes
// are taken at any time.
module open_address_hash_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key, key_hash
    input  logic [oaht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  logic [oaht_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slot, table_size, used_count
    output logic [oaht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status
    output logic [oaht_pkg::STATUS_W-1:0]       m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data
);

    localparam int IDX_W = oaht_pkg::IDX_W;
    localparam int CNT_W = oaht_pkg::CNT_W;
    localparam int NSZ_W = oaht_pkg::NSZ_W;
    localparam int MIN_W = oaht_pkg::MIN_W;
    localparam int CMP_W = oaht_pkg::CMP_W;
    localparam int LIM_W = oaht_pkg::LIM_W;
    localparam int KB    = oaht_pkg::KEY_BITS;
    localparam int HB    = oaht_pkg::HASH_BITS;

    oaht_pkg::t_state r_state, n_state;

    // control state
    logic             r_hold, n_hold;
    logic             r_bank, n_bank;
    logic             r_nbank, n_nbank;
    logic [IDX_W-1:0] r_mask, n_mask;
    logic [IDX_W-1:0] r_nmask, n_nmask;
    logic [CNT_W-1:0] r_live, n_live;
    logic [CNT_W-1:0] r_filled, n_filled;
    logic             r_grow_err, n_grow_err;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_m_valid, n_m_valid;

    // request and probe payload
    logic [oaht_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [KB-1:0]    r_key, n_key;
    logic [HB-1:0]    r_hash, n_hash;
    logic [KB-1:0]    r_pkey, n_pkey;
    logic [HB-1:0]    r_phash, n_phash;
    logic             r_pbank, n_pbank;
    logic [IDX_W-1:0] r_pmask, n_pmask;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [HB-1:0]    r_perturb, n_perturb;
    logic [LIM_W-1:0] r_steps, n_steps;
    logic             r_have_free, n_have_free;
    logic [IDX_W-1:0] r_free, n_free;
    logic             r_rsz, n_rsz;
    logic             r_found, n_found;
    logic             r_fail, n_fail;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic             r_pos_empty, n_pos_empty;
    oaht_pkg::t_phase r_phase, n_phase;
    oaht_pkg::t_ret   r_ret, n_ret;
    logic             r_ok, n_ok;
    logic [NSZ_W-1:0] r_newsize, n_newsize;
    logic [MIN_W-1:0] r_minsize, n_minsize;
    oaht_pkg::t_status r_res_status, n_res_status;
    logic [oaht_pkg::SLOT_W-1:0]   r_res_slot, n_res_slot;
    oaht_pkg::t_status             r_m_status, n_m_status;
    logic [oaht_pkg::SLOT_W-1:0]   r_m_slot, n_m_slot;
    logic [oaht_pkg::TSIZE_W-1:0]  r_m_size, n_m_size;
    logic [oaht_pkg::USED_W-1:0]   r_m_used, n_m_used;

    // memory port
    logic                          ram_we;
    logic [oaht_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [oaht_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;
    oaht_pkg::t_mark               wr_mark;

    // probe evaluation
    oaht_pkg::t_mark  rd_mark;
    logic [HB-1:0]    rd_hash;
    logic [KB-1:0]    rd_key;
    logic [IDX_W-1:0] cur_idx, step_idx, free_n;
    logic [LIM_W-1:0] limit;
    logic             rd_empty, rd_hit, at_limit, tomb_new, have_free_n, prb_done;

    // resize evaluation
    logic [CNT_W-1:0] old_size;
    logic [CMP_W-1:0] filled3, old2, live5;
    logic [MIN_W-1:0] minsize;
    logic             rsz_keep, size_grow, size_over, clr_last, src_last, cmd_ok;

    // probe launch
    logic             start_req, start_src;
    logic [KB-1:0]    sel_key;
    logic [HB-1:0]    sel_hash;

    oaht_ram #(
        .WIDTH (oaht_pkg::WORD_W),
        .DEPTH (oaht_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_mark  = oaht_pkg::t_mark'(ram_rdata[oaht_pkg::WORD_W-1 -: oaht_pkg::MARK_W]);
    assign rd_hash  = ram_rdata[KB +: HB];
    assign rd_key   = ram_rdata[KB-1:0];
    assign cur_idx  = r_idx & r_pmask;
    assign rd_empty = (rd_mark == oaht_pkg::MARK_EMPTY);
    assign rd_hit   = (rd_mark == oaht_pkg::MARK_LIVE) && (rd_hash == r_phash)
                      && (rd_key == r_pkey);
    assign limit    = LIM_W'(r_pmask) + LIM_W'(HB + 3);
    assign at_limit = (r_steps == limit);
    assign tomb_new = (rd_mark == oaht_pkg::MARK_TOMB) && !r_have_free;
    assign have_free_n = r_have_free | tomb_new;
    assign free_n   = tomb_new ? cur_idx : r_free;
    assign prb_done = r_rsz ? (rd_empty || at_limit) : (rd_empty || rd_hit || at_limit);
    // idx*5 + perturb + 1, kept to the index width
    assign step_idx = (r_idx << 2) + r_idx + r_perturb[IDX_W-1:0] + IDX_W'(1);

    assign old_size  = CNT_W'(r_mask) + CNT_W'(1);
    assign filled3   = (CMP_W'(r_filled) << 1) + CMP_W'(r_filled);
    assign old2      = CMP_W'(old_size) << 1;
    assign live5     = (CMP_W'(r_live) << 2) + CMP_W'(r_live);
    assign rsz_keep  = r_hold
                       || ((r_filled < CNT_W'(oaht_pkg::INIT_SLOTS - 1))
                           && (old_size == CNT_W'(oaht_pkg::INIT_SLOTS)))
                       || ((filled3 < old2) && (CMP_W'(old_size) < live5));
    assign minsize   = (32'(r_live) > oaht_pkg::BIG_LIVE) ? (MIN_W'(r_live) << 1)
                                                          : (MIN_W'(r_live) << 2);
    assign size_grow = (MIN_W'(r_newsize) < r_minsize)
                       && (r_newsize <= NSZ_W'(oaht_pkg::BANK_DEPTH));
    assign size_over = (r_newsize > NSZ_W'(oaht_pkg::BANK_DEPTH));
    assign clr_last  = (r_cnt == CNT_W'(r_newsize - NSZ_W'(1)));
    assign src_last  = (r_cnt == CNT_W'(r_mask));
    assign cmd_ok    = (s_axis_tuser == oaht_pkg::CMD_LOOKUP)
                       || (s_axis_tuser == oaht_pkg::CMD_ADD)
                       || (s_axis_tuser == oaht_pkg::CMD_REMOVE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oaht_pkg::S_CLEAR: begin
                if (r_cnt == CNT_W'(oaht_pkg::INIT_SLOTS - 1)) begin
                    n_state = oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = cmd_ok ? oaht_pkg::S_PRB_RD : oaht_pkg::S_FIN;
                end
            end
            oaht_pkg::S_PRB_RD: n_state = oaht_pkg::S_PRB_EV;
            oaht_pkg::S_PRB_EV: begin
                if (prb_done) begin
                    n_state = r_rsz ? oaht_pkg::S_RSZ_WR : oaht_pkg::S_DISPATCH;
                end else begin
                    n_state = oaht_pkg::S_PRB_RD;
                end
            end
            oaht_pkg::S_DISPATCH: begin
                n_state = oaht_pkg::S_FIN;
                case (r_cmd)
                    oaht_pkg::CMD_ADD: begin
                        if (r_phase == oaht_pkg::PH_FINAL || r_found) begin
                            n_state = oaht_pkg::S_FIN;
                        end else if (r_phase == oaht_pkg::PH_FIRST && r_grow_err) begin
                            n_state = oaht_pkg::S_RSZ_CHK;
                        end else if (!r_fail) begin
                            n_state = oaht_pkg::S_INSERT;
                        end
                    end
                    oaht_pkg::CMD_REMOVE: begin
                        if (r_found) begin
                            n_state = oaht_pkg::S_TOMB;
                        end
                    end
                    default: n_state = oaht_pkg::S_FIN;
                endcase
            end
            oaht_pkg::S_INSERT, oaht_pkg::S_TOMB: n_state = oaht_pkg::S_RSZ_CHK;
            oaht_pkg::S_RSZ_CHK: begin
                n_state = rsz_keep ? oaht_pkg::S_AFTER_RSZ : oaht_pkg::S_RSZ_SIZE;
            end
            oaht_pkg::S_RSZ_SIZE: begin
                if (!size_grow) begin
                    n_state = size_over ? oaht_pkg::S_AFTER_RSZ : oaht_pkg::S_RSZ_CLR;
                end
            end
            oaht_pkg::S_RSZ_CLR: begin
                if (clr_last) begin
                    n_state = oaht_pkg::S_RSZ_SRC_RD;
                end
            end
            oaht_pkg::S_RSZ_SRC_RD: n_state = oaht_pkg::S_RSZ_SRC_EV;
            oaht_pkg::S_RSZ_SRC_EV: begin
                if (rd_mark == oaht_pkg::MARK_LIVE) begin
                    n_state = oaht_pkg::S_PRB_RD;
                end else begin
                    n_state = src_last ? oaht_pkg::S_RSZ_DONE : oaht_pkg::S_RSZ_SRC_RD;
                end
            end
            oaht_pkg::S_RSZ_WR: begin
                n_state = src_last ? oaht_pkg::S_RSZ_DONE : oaht_pkg::S_RSZ_SRC_RD;
            end
            oaht_pkg::S_RSZ_DONE: n_state = oaht_pkg::S_AFTER_RSZ;
            oaht_pkg::S_AFTER_RSZ: begin
                unique case (r_ret)
                    oaht_pkg::RET_ADD_RETRY:
                        n_state = r_ok ? oaht_pkg::S_PRB_RD : oaht_pkg::S_FIN;
                    oaht_pkg::RET_ADD_DONE: n_state = oaht_pkg::S_PRB_RD;
                    oaht_pkg::RET_REMOVE:   n_state = oaht_pkg::S_FIN;
                    default:                n_state = oaht_pkg::S_FIN;
                endcase
            end
            oaht_pkg::S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = oaht_pkg::S_IDLE;
                end
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_hold = r_hold;       n_bank = r_bank;         n_nbank = r_nbank;
        n_mask = r_mask;       n_nmask = r_nmask;       n_live = r_live;
        n_filled = r_filled;   n_grow_err = r_grow_err; n_cnt = r_cnt;
        n_m_valid = r_m_valid; n_cmd = r_cmd;           n_key = r_key;
        n_hash = r_hash;       n_pkey = r_pkey;         n_phash = r_phash;
        n_pbank = r_pbank;     n_pmask = r_pmask;       n_idx = r_idx;
        n_perturb = r_perturb; n_steps = r_steps;       n_have_free = r_have_free;
        n_free = r_free;       n_rsz = r_rsz;           n_found = r_found;
        n_fail = r_fail;       n_pos = r_pos;           n_pos_empty = r_pos_empty;
        n_phase = r_phase;     n_ret = r_ret;           n_ok = r_ok;
        n_newsize = r_newsize; n_minsize = r_minsize;
        n_res_status = r_res_status; n_res_slot = r_res_slot;
        n_m_status = r_m_status;     n_m_slot = r_m_slot;
        n_m_size = r_m_size;         n_m_used = r_m_used;
        start_req = 1'b0;
        start_src = 1'b0;

        if (i_cfg_valid) begin
            n_hold = i_cfg_data;
        end
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            oaht_pkg::S_CLEAR: n_cnt = r_cnt + CNT_W'(1);
            oaht_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser;
                    n_key   = s_axis_tdata[KB-1:0];
                    n_hash  = s_axis_tdata[KB +: HB];
                    n_phase = oaht_pkg::PH_FIRST;
                    if (cmd_ok) begin
                        start_req = 1'b1;
                    end else begin
                        n_res_status = oaht_pkg::ST_FAILED;
                        n_res_slot   = '0;
                    end
                end
            end
            oaht_pkg::S_PRB_RD: ;
            oaht_pkg::S_PRB_EV: begin
                if (!prb_done) begin
                    n_idx       = step_idx;
                    n_perturb   = r_perturb >> oaht_pkg::SHIFT_STEP;
                    n_steps     = r_steps + LIM_W'(1);
                    n_have_free = have_free_n;
                    n_free      = free_n;
                end else if (r_rsz || rd_hit) begin
                    n_found     = !r_rsz;
                    n_fail      = 1'b0;
                    n_pos       = cur_idx;
                    n_pos_empty = 1'b0;
                end else if (rd_empty) begin
                    n_found     = 1'b0;
                    n_fail      = 1'b0;
                    n_pos       = r_have_free ? r_free : cur_idx;
                    n_pos_empty = !r_have_free;
                end else begin
                    // reached the step limit: fall back to the first tombstone
                    n_found     = 1'b0;
                    n_fail      = !have_free_n;
                    n_pos       = free_n;
                    n_pos_empty = 1'b0;
                end
            end
            oaht_pkg::S_DISPATCH: begin
                n_res_slot = '0;
                case (r_cmd)
                    oaht_pkg::CMD_LOOKUP: begin
                        n_res_status = r_found ? oaht_pkg::ST_FOUND : oaht_pkg::ST_NOT_FOUND;
                        if (r_found) begin
                            n_res_slot = oaht_pkg::SLOT_W'(r_pos);
                        end
                    end
                    oaht_pkg::CMD_ADD: begin
                        if (r_phase == oaht_pkg::PH_FINAL) begin
                            n_res_status = r_ok ? oaht_pkg::ST_ADDED : oaht_pkg::ST_FAILED;
                            if (r_found) begin
                                n_res_slot = oaht_pkg::SLOT_W'(r_pos);
                            end
                        end else if (r_found) begin
                            n_res_status = oaht_pkg::ST_PRESENT;
                            n_res_slot   = oaht_pkg::SLOT_W'(r_pos);
                        end else if (r_phase == oaht_pkg::PH_FIRST && r_grow_err) begin
                            n_ret = oaht_pkg::RET_ADD_RETRY;
                        end else begin
                            n_res_status = oaht_pkg::ST_FAILED;
                        end
                    end
                    oaht_pkg::CMD_REMOVE: begin
                        n_res_status = oaht_pkg::ST_NOT_FOUND;
                        n_ret        = oaht_pkg::RET_REMOVE;
                    end
                    default: n_res_status = oaht_pkg::ST_FAILED;
                endcase
            end
            oaht_pkg::S_INSERT: begin
                n_live   = r_live + CNT_W'(1);
                n_filled = r_filled + CNT_W'(r_pos_empty);
                n_ret    = oaht_pkg::RET_ADD_DONE;
            end
            oaht_pkg::S_TOMB: n_live = r_live - CNT_W'(1);
            oaht_pkg::S_RSZ_CHK: begin
                n_ok      = 1'b1;
                n_newsize = NSZ_W'(oaht_pkg::INIT_SLOTS);
                n_minsize = minsize;
            end
            oaht_pkg::S_RSZ_SIZE: begin
                if (size_grow) begin
                    n_newsize = r_newsize << 1;
                end else if (size_over) begin
                    n_ok = (r_filled < CNT_W'(r_mask));
                    if (r_filled >= CNT_W'(r_mask)) begin
                        n_grow_err = 1'b1;
                    end
                end else begin
                    n_nbank = ~r_bank;
                    n_nmask = IDX_W'(r_newsize - NSZ_W'(1));
                    n_cnt   = '0;
                end
            end
            oaht_pkg::S_RSZ_CLR: n_cnt = clr_last ? '0 : r_cnt + CNT_W'(1);
            oaht_pkg::S_RSZ_SRC_RD: ;
            oaht_pkg::S_RSZ_SRC_EV: begin
                if (rd_mark == oaht_pkg::MARK_LIVE) begin
                    start_src = 1'b1;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            oaht_pkg::S_RSZ_WR: n_cnt = r_cnt + CNT_W'(1);
            oaht_pkg::S_RSZ_DONE: begin
                n_bank     = r_nbank;
                n_mask     = r_nmask;
                n_filled   = r_live;
                n_grow_err = 1'b0;
                n_ok       = 1'b1;
            end
            oaht_pkg::S_AFTER_RSZ: begin
                n_res_slot = '0;
                unique case (r_ret)
                    oaht_pkg::RET_ADD_RETRY: begin
                        if (r_ok) begin
                            start_req = 1'b1;
                            n_phase   = oaht_pkg::PH_SECOND;
                        end else begin
                            n_res_status = oaht_pkg::ST_FAILED;
                        end
                    end
                    oaht_pkg::RET_ADD_DONE: begin
                        start_req = 1'b1;
                        n_phase   = oaht_pkg::PH_FINAL;
                    end
                    oaht_pkg::RET_REMOVE: n_res_status = oaht_pkg::ST_REMOVED;
                    default: n_res_status = oaht_pkg::ST_FAILED;
                endcase
            end
            oaht_pkg::S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_slot   = r_res_slot;
                    n_m_size   = oaht_pkg::TSIZE_W'(old_size);
                    n_m_used   = oaht_pkg::USED_W'(r_live);
                end
            end
        endcase

        // launch a probe from the request or from an entry being moved
        sel_key  = (r_state == oaht_pkg::S_IDLE) ? s_axis_tdata[KB-1:0] : r_key;
        sel_hash = (r_state == oaht_pkg::S_IDLE) ? s_axis_tdata[KB +: HB] : r_hash;
        if (start_src) begin
            sel_key  = rd_key;
            sel_hash = rd_hash;
        end
        if (start_req || start_src) begin
            n_pkey      = sel_key;
            n_phash     = sel_hash;
            n_pbank     = start_src ? r_nbank : r_bank;
            n_pmask     = start_src ? r_nmask : r_mask;
            n_idx       = sel_hash[IDX_W-1:0] & (start_src ? r_nmask : r_mask);
            n_perturb   = sel_hash;
            n_steps     = '0;
            n_have_free = 1'b0;
            n_rsz       = start_src;
        end
    end

    // memory control and handshakes
    always_comb begin
        s_axis_tready = (r_state == oaht_pkg::S_IDLE);
        ram_we    = 1'b0;
        wr_mark   = oaht_pkg::MARK_EMPTY;
        ram_waddr = {r_nbank, r_pos};
        ram_raddr = {r_pbank, cur_idx};
        unique case (r_state)
            oaht_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = {1'b0, r_cnt[IDX_W-1:0]};
            end
            oaht_pkg::S_INSERT: begin
                ram_we    = 1'b1;
                wr_mark   = oaht_pkg::MARK_LIVE;
                ram_waddr = {r_bank, r_pos};
            end
            oaht_pkg::S_TOMB: begin
                ram_we    = 1'b1;
                wr_mark   = oaht_pkg::MARK_TOMB;
                ram_waddr = {r_bank, r_pos};
            end
            oaht_pkg::S_RSZ_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = {r_nbank, r_cnt[IDX_W-1:0]};
            end
            oaht_pkg::S_RSZ_SRC_RD: ram_raddr = {r_bank, r_cnt[IDX_W-1:0]};
            oaht_pkg::S_RSZ_WR: begin
                ram_we  = 1'b1;
                wr_mark = oaht_pkg::MARK_LIVE;
            end
            default: ;
        endcase
        ram_wdata = {wr_mark, r_phash, r_pkey};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= oaht_pkg::S_CLEAR;
            r_hold     <= 1'b0;
            r_bank     <= 1'b0;
            r_mask     <= IDX_W'(oaht_pkg::INIT_SLOTS - 1);
            r_live     <= '0;
            r_filled   <= '0;
            r_grow_err <= 1'b0;
            r_cnt      <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hold     <= n_hold;
            r_bank     <= n_bank;
            r_mask     <= n_mask;
            r_live     <= n_live;
            r_filled   <= n_filled;
            r_grow_err <= n_grow_err;
            r_cnt      <= n_cnt;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nbank      <= n_nbank;
        r_nmask      <= n_nmask;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_hash       <= n_hash;
        r_pkey       <= n_pkey;
        r_phash      <= n_phash;
        r_pbank      <= n_pbank;
        r_pmask      <= n_pmask;
        r_idx        <= n_idx;
        r_perturb    <= n_perturb;
        r_steps      <= n_steps;
        r_have_free  <= n_have_free;
        r_free       <= n_free;
        r_rsz        <= n_rsz;
        r_found      <= n_found;
        r_fail       <= n_fail;
        r_pos        <= n_pos;
        r_pos_empty  <= n_pos_empty;
        r_phase      <= n_phase;
        r_ret        <= n_ret;
        r_ok         <= n_ok;
        r_newsize    <= n_newsize;
        r_minsize    <= n_minsize;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_m_status   <= n_m_status;
        r_m_slot     <= n_m_slot;
        r_m_size     <= n_m_size;
        r_m_used     <= n_m_used;
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = oaht_pkg::OUT_TDATA_W'({r_m_used, r_m_size, r_m_slot});

endmodule

// ===== src/oaht_checker.sv =====
`include "open_address_hash_table_macros.svh"

module oaht_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [oaht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input logic [oaht_pkg::CMD_W-1:0]          s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [oaht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [oaht_pkg::STATUS_W-1:0]       m_axis_tuser,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic                                i_cfg_data
);

    `OAHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `OAHT_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
    `OAHT_ASSERT_SAME(a_size_pow2, i_clk, i_rst_n, m_axis_tvalid, $onehot(m_axis_tdata[20:10]) && (m_axis_tdata[20:10] >= 11'(oaht_pkg::INIT_SLOTS)), "table size not a power of two")
    `OAHT_ASSERT_SAME(a_used_fits, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[31:21] <= m_axis_tdata[20:10], "more live entries than slots")
    `OAHT_ASSERT_SAME(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= oaht_pkg::ST_FAILED, "undefined status")

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (.*);
